/* design/rc6_block_cipher_ecb_cbc_core_assert.svh */
// Assertion macros for the RC6 block cipher core.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef RC6_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH
`define RC6_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RC6_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RC6_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rc6_pkg.sv */
// Shared types, constants and word functions for the RC6 block cipher core.
// No dependencies; used by the controller, datapath and top level.
package rc6_pkg;

	localparam int unsigned NUM_ROUNDS_DEF = 20;
	localparam int unsigned BLK_W = 128;
	localparam int unsigned CFG_W = 64;
	localparam int unsigned PADDR_W = 6;

	localparam logic [31:0] MAGIC_P = 32'hB7E15163;
	localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

	localparam logic [2:0] REG_KEY_LOW = 3'd0;
	localparam logic [2:0] REG_KEY_HIGH = 3'd1;
	localparam logic [2:0] REG_IV_LOW = 3'd2;
	localparam logic [2:0] REG_IV_HIGH = 3'd3;
	localparam logic [2:0] REG_DIRECTION = 3'd4;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd5;

	typedef struct packed {
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [63:0] iv_low;
		logic [63:0] iv_high;
		logic direction;
		logic chain_mode;
	} rc6_cfg_t;

	typedef struct packed {
		logic accept;
		logic ks_init;
		logic ks_a;
		logic ks_b;
		logic load;
		logic pre1;
		logic pre2;
		logic mix;
		logic rnd;
		logic post1;
		logic post2;
		logic finish;
	} rc6_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rc6_sts_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] tmp;
		tmp = {x, x} << n;
		return tmp[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] tmp;
		tmp = {x, x} >> n;
		return tmp[31:0];
	endfunction

	function automatic logic [31:0] mixf(input logic [31:0] x);
		logic [31:0] prod;
		prod = x * {x[30:0], 1'b1};
		return {prod[26:0], prod[31:27]};
	endfunction

endpackage

/* design/rc6_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rc6_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 44
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/rc6_ctrl.sv */
// Sequencing state machine for the RC6 core: key schedule, rounds, result hand-off.
// Depends on rc6_pkg for the command and status structs.
module rc6_ctrl #(
	parameter int unsigned NUM_ROUNDS = rc6_pkg::NUM_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_first,
	output logic in_ready,
	input rc6_pkg::rc6_sts_t sts,
	output rc6_pkg::rc6_cmd_t cmd
);

	localparam int unsigned RkCount = 2 * NUM_ROUNDS + 4;
	localparam int unsigned StepW = $clog2(3 * RkCount);
	localparam int unsigned RndW = $clog2(NUM_ROUNDS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_KSA = 4'd1;
	localparam logic [3:0] ST_KSB = 4'd2;
	localparam logic [3:0] ST_LOAD = 4'd3;
	localparam logic [3:0] ST_PRE1 = 4'd4;
	localparam logic [3:0] ST_PRE2 = 4'd5;
	localparam logic [3:0] ST_MIX = 4'd6;
	localparam logic [3:0] ST_RND = 4'd7;
	localparam logic [3:0] ST_POST1 = 4'd8;
	localparam logic [3:0] ST_POST2 = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] state_q, state_d;
	logic [StepW-1:0] step_q, step_d;
	logic [RndW-1:0] rnd_q, rnd_d;

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		rnd_d = rnd_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					cmd.ks_init = in_first;
					step_d = '0;
					state_d = in_first ? ST_KSA : ST_LOAD;
				end
			end
			ST_KSA: begin
				cmd.ks_a = 1'b1;
				state_d = ST_KSB;
			end
			ST_KSB: begin
				cmd.ks_b = 1'b1;
				step_d = step_q + 1'b1;
				state_d = (step_q == StepW'(3 * RkCount - 1)) ? ST_LOAD : ST_KSA;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_PRE1;
			end
			ST_PRE1: begin
				cmd.pre1 = 1'b1;
				state_d = ST_PRE2;
			end
			ST_PRE2: begin
				cmd.pre2 = 1'b1;
				rnd_d = RndW'(1);
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				rnd_d = rnd_q + 1'b1;
				state_d = (rnd_q == RndW'(NUM_ROUNDS)) ? ST_POST1 : ST_MIX;
			end
			ST_POST1: begin
				cmd.post1 = 1'b1;
				state_d = ST_POST2;
			end
			ST_POST2: begin
				cmd.post2 = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			rnd_q <= rnd_d;
		end
	end

endmodule

/* design/rc6_dp.sv */
// Datapath of the RC6 core: key schedule, round logic, chain and result registers.
// Depends on rc6_pkg and rc6_ram (round-key store).
module rc6_dp #(
	parameter int unsigned NUM_ROUNDS = rc6_pkg::NUM_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input rc6_pkg::rc6_cfg_t cfg,
	input rc6_pkg::rc6_cmd_t cmd,
	output rc6_pkg::rc6_sts_t sts,
	input logic [rc6_pkg::BLK_W-1:0] in_data,
	output logic [rc6_pkg::BLK_W-1:0] out_data,
	output logic out_valid,
	input logic out_ready
);

	localparam int unsigned RkCount = 2 * NUM_ROUNDS + 4;
	localparam int unsigned AW = $clog2(RkCount);

	logic [31:0] a_q, b_q, c_q, d_q, t_q, u_q, rk_q;
	logic [31:0] ka_q, kb_q, pq_q;
	logic [31:0] kw_q [4];
	logic [AW-1:0] i_q, rptr_q;
	logic [1:0] j_q;
	logic first_pass_q;
	logic [rc6_pkg::BLK_W-1:0] in_q, out_q, chain_q;
	logic out_valid_q;

	logic enc, cbc;
	logic [AW-1:0] i_next, rstart, raddr;
	logic [31:0] rdata, ks_src, ks_sum, ks_a_new, ks_b_new;
	logic [31:0] mix_x0, mix_x1, e_a, e_c, r_a, r_c;
	logic [rc6_pkg::BLK_W-1:0] blk, res, load_blk;

	assign enc = cfg.direction;
	assign cbc = cfg.chain_mode;
	assign i_next = (i_q == AW'(RkCount - 1)) ? '0 : i_q + 1'b1;
	assign rstart = enc ? '0 : AW'(RkCount - 1);
	assign raddr = cmd.ks_b ? i_next : (cmd.load ? rstart : rptr_q);

	assign ks_src = first_pass_q ? pq_q : rdata;
	assign ks_a_new = rc6_pkg::rotl32(ks_src + ka_q + kb_q, 5'd3);
	assign ks_sum = ka_q + kb_q;
	assign ks_b_new = rc6_pkg::rotl32(kw_q[j_q] + ks_sum, ks_sum[4:0]);

	assign mix_x0 = enc ? b_q : a_q;
	assign mix_x1 = enc ? d_q : c_q;
	assign e_a = rc6_pkg::rotl32(a_q ^ t_q, u_q[4:0]) + rk_q;
	assign e_c = rc6_pkg::rotl32(c_q ^ u_q, t_q[4:0]) + rdata;
	assign r_c = rc6_pkg::rotr32(c_q - rk_q, t_q[4:0]) ^ u_q;
	assign r_a = rc6_pkg::rotr32(a_q - rdata, u_q[4:0]) ^ t_q;

	assign blk = {d_q, c_q, b_q, a_q};
	assign res = (!enc && cbc) ? (blk ^ chain_q) : blk;
	assign load_blk = (enc && cbc) ? (in_q ^ chain_q) : in_q;

	rc6_ram #(
		.WIDTH(32),
		.DEPTH(RkCount)
	) u_rk_ram (
		.clk(clk),
		.we(cmd.ks_a),
		.waddr(i_q),
		.wdata(ks_a_new),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chain_q <= '0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.ks_init) begin
				chain_q <= {cfg.iv_high, cfg.iv_low};
			end else if (cmd.finish && cbc) begin
				chain_q <= enc ? blk : in_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q <= in_data;
		end
		if (cmd.ks_init) begin
			kw_q[0] <= cfg.key_low[31:0];
			kw_q[1] <= cfg.key_low[63:32];
			kw_q[2] <= cfg.key_high[31:0];
			kw_q[3] <= cfg.key_high[63:32];
			ka_q <= '0;
			kb_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pq_q <= rc6_pkg::MAGIC_P;
			first_pass_q <= 1'b1;
		end
		if (cmd.ks_a) begin
			ka_q <= ks_a_new;
			pq_q <= pq_q + rc6_pkg::MAGIC_Q;
		end
		if (cmd.ks_b) begin
			kw_q[j_q] <= ks_b_new;
			kb_q <= ks_b_new;
			i_q <= i_next;
			j_q <= j_q + 1'b1;
			if (i_q == AW'(RkCount - 1)) begin
				first_pass_q <= 1'b0;
			end
		end
		if (cmd.load) begin
			rptr_q <= enc ? rstart + 1'b1 : rstart - 1'b1;
		end else begin
			rptr_q <= enc ? rptr_q + 1'b1 : rptr_q - 1'b1;
		end
		if (cmd.load) begin
			{d_q, c_q, b_q, a_q} <= load_blk;
		end
		if (cmd.pre1) begin
			if (enc) begin
				b_q <= b_q + rdata;
			end else begin
				c_q <= c_q - rdata;
			end
		end
		if (cmd.pre2) begin
			if (enc) begin
				d_q <= d_q + rdata;
			end else begin
				a_q <= a_q - rdata;
			end
		end
		if (cmd.mix) begin
			t_q <= rc6_pkg::mixf(mix_x0);
			u_q <= rc6_pkg::mixf(mix_x1);
			rk_q <= rdata;
			if (!enc) begin
				a_q <= d_q;
				b_q <= a_q;
				c_q <= b_q;
				d_q <= c_q;
			end
		end
		if (cmd.rnd) begin
			if (enc) begin
				a_q <= b_q;
				b_q <= e_c;
				c_q <= d_q;
				d_q <= e_a;
			end else begin
				a_q <= r_a;
				c_q <= r_c;
			end
		end
		if (cmd.post1) begin
			if (enc) begin
				a_q <= a_q + rdata;
			end else begin
				d_q <= d_q - rdata;
			end
		end
		if (cmd.post2) begin
			if (enc) begin
				c_q <= c_q + rdata;
			end else begin
				b_q <= b_q - rdata;
			end
		end
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_data = out_q;
	assign out_valid = out_valid_q;

endmodule

/* design/rc6_block_cipher_ecb_cbc_core.sv */
// Top level of the RC6-32/R/16 block cipher core with ECB and CBC chaining.
// Depends on rc6_pkg, rc6_ctrl, rc6_dp, rc6_ram and the assertion header.
//
// Blocks arrive on the s_ stream as one 128-bit transaction, word 0 in the
// lowest bits; s_tuser marks the first block of a message. Results leave on
// the m_ stream in the same packing. Key, IV, direction and mode are to be
// set through the APB port only while the core is idle; the core does not enforce it.
// A first block runs the key schedule: 3*(2*NUM_ROUNDS+4) mixing steps
// (132 steps at 20 rounds), each an A update (ST_KSA) then a B update
// (ST_KSB), set by the add-rotate chain and the single-write key store.
// Every block then runs from acceptance to m_tvalid through one load, two
// whitening steps, two states per round (multiply, then rotate and add) and
// two final whitening steps. s_tready rises again in the same cycle as
// m_tvalid, so a new block is accepted only once the last one is through.
// The result register lets a new block be accepted while the last result
// waits; if the receiver still stalls when the next result is ready, the
// core holds it internally until the register frees.
// Reset clears the chain register and m_tvalid and sets encrypt, ECB.
`include "rc6_block_cipher_ecb_cbc_core_assert.svh"

module rc6_block_cipher_ecb_cbc_core #(
	parameter int unsigned NUM_ROUNDS = rc6_pkg::NUM_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rc6_pkg::PADDR_W-1:0] paddr,
	input logic [rc6_pkg::CFG_W-1:0] pwdata,
	output logic [rc6_pkg::CFG_W-1:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	// word0 [31:0], word1 [63:32], word2 [95:64], word3 [127:96]
	input logic [rc6_pkg::BLK_W-1:0] s_tdata,
	// first_block [0]
	input logic [0:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// out_word0 [31:0], out_word1 [63:32], out_word2 [95:64], out_word3 [127:96]
	output logic [rc6_pkg::BLK_W-1:0] m_tdata
);

	rc6_pkg::rc6_cfg_t cfg_q;
	rc6_pkg::rc6_cmd_t cmd;
	rc6_pkg::rc6_sts_t sts;
	logic [2:0] reg_idx;
	logic cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{key_low: '0, key_high: '0, iv_low: '0, iv_high: '0,
				direction: 1'b1, chain_mode: 1'b0};
		end else if (cfg_wr) begin
			case (reg_idx)
				rc6_pkg::REG_KEY_LOW: cfg_q.key_low <= pwdata;
				rc6_pkg::REG_KEY_HIGH: cfg_q.key_high <= pwdata;
				rc6_pkg::REG_IV_LOW: cfg_q.iv_low <= pwdata;
				rc6_pkg::REG_IV_HIGH: cfg_q.iv_high <= pwdata;
				rc6_pkg::REG_DIRECTION: cfg_q.direction <= pwdata[0];
				rc6_pkg::REG_CHAIN_MODE: cfg_q.chain_mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rc6_pkg::REG_KEY_LOW: prdata = cfg_q.key_low;
			rc6_pkg::REG_KEY_HIGH: prdata = cfg_q.key_high;
			rc6_pkg::REG_IV_LOW: prdata = cfg_q.iv_low;
			rc6_pkg::REG_IV_HIGH: prdata = cfg_q.iv_high;
			rc6_pkg::REG_DIRECTION: prdata = {{(rc6_pkg::CFG_W-1){1'b0}}, cfg_q.direction};
			rc6_pkg::REG_CHAIN_MODE: prdata = {{(rc6_pkg::CFG_W-1){1'b0}}, cfg_q.chain_mode};
			default: prdata = '0;
		endcase
	end

	rc6_ctrl #(
		.NUM_ROUNDS(NUM_ROUNDS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_first(s_tuser[0]),
		.in_ready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	rc6_dp #(
		.NUM_ROUNDS(NUM_ROUNDS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.sts(sts),
		.in_data(s_tdata),
		.out_data(m_tdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready)
	);

	`RC6_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted a block while busy")
	`RC6_ASSERT_NEXT(a_first_runs_schedule, s_tvalid && s_tready && s_tuser[0], cmd.ks_a, "first block skipped key schedule")
	`RC6_ASSERT_NOW(a_no_overwrite, cmd.finish, !(m_tvalid && !m_tready), "result overwrote a pending transaction")

endmodule
